### hw/rtl/kfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfr_pkg
// Shared types and constants for the k-line frame receiver.
// ----------------------------------------------------------------------------
package kfr_pkg;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ADDR = 2'd1;
	localparam logic [1:0] ST_BAD_SUM  = 2'd2;
	localparam logic [1:0] ST_BAD_LEN  = 2'd3;

	// reset value of the match address register
	localparam logic [7:0] MATCH_RESET = 8'hF4;

	// command handed from the front to the back
	typedef struct packed {
		logic       is_err;
		logic [1:0] status;
		logic [6:0] total;
	} cmd_t;

endpackage

### hw/rtl/kfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfr_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/kfr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfr_cmd_fifo
// Two entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module kfr_cmd_fifo
	import kfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head  = entry_q[rd_ptr_q];
	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### hw/rtl/kfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfr_front
// Accepts line beats, tracks the frame, stores bytes and queues commands.
// ----------------------------------------------------------------------------
module kfr_front
	import kfr_pkg::*;
#(
	parameter int FRAME_LIMIT = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [7:0]                     cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [7:0]                     rx_byte,
	input  logic                           fifo_full,
	output logic                           push,
	output cmd_t                           push_cmd,
	input  logic                           replay_done,
	output logic                           wr_en,
	output logic [$clog2(FRAME_LIMIT)-1:0] wr_addr,
	output logic [7:0]                     wr_data
);

	localparam int AW = $clog2(FRAME_LIMIT);
	localparam logic [6:0] LIMIT7  = 7'(FRAME_LIMIT);
	localparam logic [7:0] LEN_MAX = 8'(FRAME_LIMIT - 2);

	logic       addr_miss;
	logic [7:0] match_addr_q;
	logic       recv_q;
	logic [6:0] fill_q;
	logic [7:0] xor_q;
	logic [7:0] len_q;
	logic       pend_q;

	logic       accept;
	logic       recv_n;
	logic [6:0] fill_n;
	logic [7:0] xor_n;
	logic [6:0] fill_c;
	logic [7:0] xor_c;
	logic [8:0] total_c;
	logic       set_pend;

	// hold input while the queue is full or a replay still reads the buffer
	assign in_stall  = fifo_full || pend_q;
	assign accept    = in_valid && !in_stall;
	assign addr_miss = (fill_q == 7'd0) && (rx_byte != match_addr_q);

	assign wr_addr = fill_q[AW-1:0];
	assign wr_data = rx_byte;
	assign fill_c  = fill_q + 7'd1;
	assign xor_c   = xor_q ^ rx_byte;
	assign total_c = 9'(len_q) + 9'd2;

	// classify the accepted beat
	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		wr_en    = 1'b0;
		set_pend = 1'b0;
		recv_n   = recv_q;
		fill_n   = fill_q;
		xor_n    = xor_q;
		if (accept) begin
			if (action) begin
				recv_n = 1'b1;
				fill_n = 7'd0;
				xor_n  = 8'd0;
			end else if (recv_q) begin
				if (addr_miss) begin
					push            = 1'b1;
					push_cmd.is_err = 1'b1;
					push_cmd.status = ST_BAD_ADDR;
					recv_n          = 1'b0;
				end else if (fill_q >= LIMIT7) begin
					push            = 1'b1;
					push_cmd.is_err = 1'b1;
					push_cmd.status = ST_BAD_LEN;
					recv_n          = 1'b0;
				end else begin
					wr_en  = 1'b1;
					fill_n = fill_c;
					xor_n  = xor_c;
					if (fill_c == 7'd2) begin
						// length byte: zero or too long for the buffer
						if ((rx_byte == 8'd0) || (rx_byte > LEN_MAX)) begin
							push            = 1'b1;
							push_cmd.is_err = 1'b1;
							push_cmd.status = ST_BAD_LEN;
							recv_n          = 1'b0;
						end
					end else if ((fill_c > 7'd2) && (9'(fill_c) == total_c)) begin
						if (xor_c != 8'd0) begin
							push            = 1'b1;
							push_cmd.is_err = 1'b1;
							push_cmd.status = ST_BAD_SUM;
							recv_n          = 1'b0;
						end else begin
							push            = 1'b1;
							push_cmd.status = ST_OK;
							push_cmd.total  = 7'(total_c);
							set_pend        = 1'b1;
							fill_n          = 7'd0;
							xor_n           = 8'd0;
						end
					end
				end
			end
		end
	end

	// frame tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_addr_q <= MATCH_RESET;
			recv_q       <= 1'b0;
			fill_q       <= 7'd0;
			xor_q        <= 8'd0;
			pend_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				match_addr_q <= cfg_wr_data;
			end
			recv_q <= recv_n;
			fill_q <= fill_n;
			xor_q  <= xor_n;
			if (set_pend) begin
				pend_q <= 1'b1;
			end else if (replay_done) begin
				pend_q <= 1'b0;
			end
		end
	end

	// length byte copy
	always_ff @(posedge clk) begin
		if (wr_en && (fill_q == 7'd1)) begin
			len_q <= rx_byte;
		end
	end

endmodule

### hw/rtl/kfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfr_back
// Pops commands, replays good frames from the buffer, emits error beats.
// ----------------------------------------------------------------------------
module kfr_back
	import kfr_pkg::*;
#(
	parameter int FRAME_LIMIT = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmd_t                           head,
	input  logic                           fifo_empty,
	output logic                           pop,
	output logic                           rd_en,
	output logic [$clog2(FRAME_LIMIT)-1:0] rd_addr,
	input  logic [7:0]                     rd_data,
	output logic                           replay_done,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [7:0]                     frame_byte,
	output logic [5:0]                     byte_index,
	output logic                           last
);

	localparam int AW = $clog2(FRAME_LIMIT);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_SEND = 2'd2;

	logic [1:0]    state_q;
	logic [AW-1:0] idx_q;
	logic [6:0]    total_q;
	logic          out_valid_q;

	logic          slot_free;
	logic          is_last;
	logic          load;
	logic [1:0]    ld_status;
	logic [7:0]    ld_byte;
	logic [5:0]    ld_index;
	logic          ld_last;

	assign slot_free = !out_valid_q || !out_stall;
	assign is_last   = ((7'(idx_q) + 7'd1) == total_q);
	assign out_valid = out_valid_q;

	// command pop, buffer read and output load
	always_comb begin
		pop         = 1'b0;
		load        = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = idx_q;
		replay_done = 1'b0;
		ld_status   = ST_OK;
		ld_byte     = rd_data;
		ld_index    = 6'(idx_q);
		ld_last     = is_last;
		case (state_q)
			S_IDLE: begin
				ld_status = head.status;
				ld_byte   = 8'd0;
				ld_index  = 6'd0;
				ld_last   = 1'b1;
				if (!fifo_empty) begin
					if (!head.is_err) begin
						pop = 1'b1;
					end else if (slot_free) begin
						pop  = 1'b1;
						load = 1'b1;
					end
				end
			end
			S_READ: begin
				rd_en = 1'b1;
			end
			S_SEND: begin
				if (slot_free) begin
					load = 1'b1;
					if (is_last) begin
						replay_done = 1'b1;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
					end
				end
			end
			default: begin
				ld_last = 1'b0;
			end
		endcase
	end

	// replay sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			total_q     <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop && !head.is_err) begin
						total_q <= head.total;
						idx_q   <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (load) begin
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			status     <= ld_status;
			frame_byte <= ld_byte;
			byte_index <= ld_index;
			last       <= ld_last;
		end
	end

endmodule

### hw/rtl/kline_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kline_frame_receiver
// K-line frame receiver: address match, length and XOR checksum check,
// replay of good frames byte by beat, one error beat for a bad frame.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  in       | in_valid/in_stall  | action, rx_byte
//  out      | out_valid/out_stall| status, frame_byte, byte_index, last
//  cfg      | cfg_wr_en          | cfg_wr_data (match address)
//
// a good frame is pushed to the queue with its last byte, popped from the
// queue, read through the registered buffer port, then replayed at one beat
// per cycle while the output does not stall; the input stalls until the
// replay ends, and longer behind queued error beats and output stalls; a
// full command queue also stalls the input.
// reset clears all control state; the buffer needs no clearing pass.
module kline_frame_receiver
	import kfr_pkg::*;
#(
	parameter int FRAME_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] frame_byte,
	output logic [5:0] byte_index,
	output logic       last
);

	localparam int FRAME_LIMIT = (FRAME_DEPTH < 64) ? FRAME_DEPTH : 64;
	localparam int AW          = $clog2(FRAME_LIMIT);

	cmd_t          push_cmd;
	cmd_t          head;
	logic          push;
	logic          pop;
	logic          fifo_empty;
	logic          fifo_full;
	logic          replay_done;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	// front end: classify beats and fill the buffer
	kfr_front #(
		.FRAME_LIMIT(FRAME_LIMIT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.rx_byte    (rx_byte),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_cmd   (push_cmd),
		.replay_done(replay_done),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// command queue
	kfr_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.empty   (fifo_empty),
		.full    (fifo_full)
	);

	// frame buffer
	kfr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_LIMIT)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// back end: replay and error beats
	kfr_back #(
		.FRAME_LIMIT(FRAME_LIMIT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.fifo_empty (fifo_empty),
		.pop        (pop),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.replay_done(replay_done),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.frame_byte (frame_byte),
		.byte_index (byte_index),
		.last       (last)
	);

endmodule
